// ===== rtl/volume_moment_covariance_defines.svh =====
// Assertion helpers for the RTL, included by vmc_ctrl.
`ifndef VOLUME_MOMENT_COVARIANCE_DEFINES_SVH
`define VOLUME_MOMENT_COVARIANCE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VMC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmc check failed");

// Next-cycle implication, checked out of reset.
`define VMC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmc check failed");

`endif

// ===== rtl/vmc_pkg.sv =====
package vmc_pkg;

    localparam int MAX_DIM_DEF    = 256;
    localparam int VOXEL_BITS_DEF = 16;

    localparam int VOXEL_PORT_BITS = 16;
    localparam int CFG_BITS        = 9;
    localparam int CFG_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    localparam int W_BITS    = 40;
    localparam int M1_BITS   = 48;
    localparam int M2_BITS   = 56;
    localparam int FRAC_BITS = 16;
    localparam int QUO_BITS  = 32;
    localparam int DVD_BITS  = M2_BITS + FRAC_BITS;
    localparam int DIV_STEPS = DVD_BITS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);

    localparam int MEAN_BITS = 25;
    localparam int VAR_BITS  = 31;
    localparam int COV_BITS  = 32;

    localparam int NUM_AXES  = 3;
    localparam int NUM_PAIRS = 6;
    localparam int NUM_DIVS  = NUM_AXES + NUM_PAIRS;
    localparam int K_BITS    = $clog2(NUM_DIVS);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_DEPTH  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic              accept;
        logic              clear;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic              set_empty;
        logic [K_BITS-1:0] k;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic w_zero;
    } status_t;

    // Pair order: xx yy zz xy yz xz
    function automatic logic [1:0] pair_a(input logic [2:0] j);
        logic [1:0] r;
        case (j)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_b(input logic [2:0] j);
        logic [1:0] r;
        case (j)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd2;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/vmc_ctrl.sv =====
`include "volume_moment_covariance_defines.svh"

module vmc_ctrl
    import vmc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  logic    cfg_clear,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_RUN    = 5'b00001,
        ST_SETTLE = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DIV_STEPS - 1);
    localparam logic [K_BITS-1:0]    K_LAST    = K_BITS'(NUM_DIVS - 1);

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [K_BITS-1:0]    k_reg, k_next;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        k_next        = k_reg;
        cmd.accept    = 1'b0;
        cmd.clear     = cfg_clear;
        cmd.div_load  = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.div_store = 1'b0;
        cmd.set_empty = 1'b0;
        cmd.k         = k_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.last)
                begin
                    state_next = ST_SETTLE;
                    k_next     = '0;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.w_zero)
                begin
                    cmd.set_empty = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    cmd.div_store = 1'b1;
                    if (k_reg == K_LAST)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            step_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
        end
    end

    `VMC_ASSERT_NOW(a_ready_excludes_result, in_ready, !out_valid)
    `VMC_ASSERT_NEXT(a_last_voxel_settles, in_valid && in_ready && status.last, state_reg == ST_SETTLE)
    `VMC_ASSERT_NOW(a_store_on_final_step, cmd.div_store, step_reg == STEP_LAST)

endmodule

// ===== rtl/vmc_datapath.sv =====
module vmc_datapath
    import vmc_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int VOXEL_BITS = VOXEL_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic [CFG_BITS-1:0]        cfg_width,
    input  logic [CFG_BITS-1:0]        cfg_height,
    input  logic [CFG_BITS-1:0]        cfg_depth,
    input  logic [VOXEL_PORT_BITS-1:0] voxel_value,
    output logic [MEAN_BITS-1:0]       mean_x,
    output logic [MEAN_BITS-1:0]       mean_y,
    output logic [MEAN_BITS-1:0]       mean_z,
    output logic [VAR_BITS-1:0]        cov_xx,
    output logic [VAR_BITS-1:0]        cov_yy,
    output logic [VAR_BITS-1:0]        cov_zz,
    output logic signed [COV_BITS-1:0] cov_xy,
    output logic signed [COV_BITS-1:0] cov_yz,
    output logic signed [COV_BITS-1:0] cov_xz,
    output logic                       empty_volume
);

    localparam int PW   = ($clog2(MAX_DIM) > 0) ? $clog2(MAX_DIM) : 1;
    localparam int CW   = ($clog2(MAX_DIM + 1) > CFG_BITS) ? $clog2(MAX_DIM + 1) : CFG_BITS + 1;
    localparam int MW   = PW + FRAC_BITS + 1;
    localparam int PPW  = 2 * CW;
    localparam int CVW  = CW + VOXEL_BITS;
    localparam int SPW  = PPW + VOXEL_BITS;
    localparam int PRW  = 2 * MW;

    function automatic logic [CW-1:0] eff_dim(input logic [CFG_BITS-1:0] r);
        logic [CW-1:0] e;
        e = CW'(r);
        if (r == '0)
            return CW'(1);
        else if (e > CW'(MAX_DIM))
            return CW'(MAX_DIM);
        else
            return e;
    endfunction

    logic [PW-1:0]         pos_reg [NUM_AXES];
    logic [CW-1:0]         coord [NUM_AXES];
    logic [CW-1:0]         dim [NUM_AXES];
    logic                  at_end [NUM_AXES];

    logic [VOXEL_BITS-1:0] v_in;
    logic [VOXEL_BITS-1:0] v_reg;
    logic                  vld_reg;
    logic [CVW-1:0]        cv_reg [NUM_AXES];
    logic [PPW-1:0]        pp_reg [NUM_PAIRS];

    logic [W_BITS-1:0]     w_reg;
    logic [M1_BITS-1:0]    m1_reg [NUM_AXES];
    logic [M2_BITS-1:0]    m2_reg [NUM_PAIRS];

    logic [DVD_BITS-1:0]   dvd_reg;
    logic [W_BITS-1:0]     rem_reg;
    logic [QUO_BITS-1:0]   quo_reg;
    logic [M2_BITS-1:0]    num;
    logic [W_BITS:0]       rem_sh;
    logic [W_BITS:0]       rem_sub;
    logic                  q_bit;
    logic [W_BITS-1:0]     rem_next;
    logic [QUO_BITS-1:0]   quo_next;
    logic [2:0]            j_idx;
    logic [K_BITS-1:0]     j_full;

    logic [MW-1:0]         mean_reg [NUM_AXES];
    logic [PRW-1:0]        prod_reg;
    logic [63:0]           prod_ext;
    logic [QUO_BITS-1:0]   cov_reg [NUM_PAIRS];
    logic                  empty_reg;
    logic [63:0]           mean_ext [NUM_AXES];

    assign v_in   = voxel_value[VOXEL_BITS-1:0];
    assign dim[0] = eff_dim(cfg_width);
    assign dim[1] = eff_dim(cfg_height);
    assign dim[2] = eff_dim(cfg_depth);

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            coord[a]  = CW'(pos_reg[a]) + CW'(1);
            at_end[a] = (coord[a] >= dim[a]);
        end
    end

    assign status.last   = at_end[0] && at_end[1] && at_end[2];
    assign status.w_zero = (w_reg == '0);

    // Position counters, x fastest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
                pos_reg[a] <= '0;
        end
        else if (cmd.clear)
        begin
            for (int a = 0; a < NUM_AXES; a++)
                pos_reg[a] <= '0;
        end
        else if (cmd.accept)
        begin
            if (at_end[0])
            begin
                pos_reg[0] <= '0;
                if (at_end[1])
                begin
                    pos_reg[1] <= '0;
                    pos_reg[2] <= at_end[2] ? '0 : pos_reg[2] + 1'b1;
                end
                else
                begin
                    pos_reg[1] <= pos_reg[1] + 1'b1;
                end
            end
            else
            begin
                pos_reg[0] <= pos_reg[0] + 1'b1;
            end
        end
    end

    // Product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= cmd.accept;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            v_reg <= v_in;
            for (int a = 0; a < NUM_AXES; a++)
                cv_reg[a] <= CVW'(coord[a]) * CVW'(v_in);
            for (int p = 0; p < NUM_PAIRS; p++)
                pp_reg[p] <= PPW'(coord[pair_a(3'(p))]) * PPW'(coord[pair_b(3'(p))]);
        end
    end

    // Moment accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
            for (int a = 0; a < NUM_AXES; a++)
                m1_reg[a] <= '0;
            for (int p = 0; p < NUM_PAIRS; p++)
                m2_reg[p] <= '0;
        end
        else if (cmd.clear)
        begin
            w_reg <= '0;
            for (int a = 0; a < NUM_AXES; a++)
                m1_reg[a] <= '0;
            for (int p = 0; p < NUM_PAIRS; p++)
                m2_reg[p] <= '0;
        end
        else if (vld_reg)
        begin
            w_reg <= w_reg + W_BITS'(v_reg);
            for (int a = 0; a < NUM_AXES; a++)
                m1_reg[a] <= m1_reg[a] + M1_BITS'(cv_reg[a]);
            for (int p = 0; p < NUM_PAIRS; p++)
                m2_reg[p] <= m2_reg[p] + M2_BITS'(SPW'(pp_reg[p]) * SPW'(v_reg));
        end
    end

    // Restoring divider: one quotient bit of (num * 2^16) / W per step
    assign j_full = cmd.k - K_BITS'(NUM_AXES);
    assign j_idx  = j_full[2:0];

    always_comb
    begin
        if (cmd.k < K_BITS'(NUM_AXES))
            num = M2_BITS'(m1_reg[cmd.k[1:0]]);
        else
            num = m2_reg[j_idx];
    end

    assign rem_sh   = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign rem_sub  = rem_sh - {1'b0, w_reg};
    assign q_bit    = (rem_sh >= {1'b0, w_reg});
    assign rem_next = q_bit ? rem_sub[W_BITS-1:0] : rem_sh[W_BITS-1:0];
    assign quo_next = {quo_reg[QUO_BITS-2:0], q_bit};
    assign prod_ext = 64'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvd_reg <= {num, FRAC_BITS'(0)};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[DVD_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        // Means are final before any pair division starts
        prod_reg <= PRW'(mean_reg[pair_a(j_idx)]) * PRW'(mean_reg[pair_b(j_idx)]);
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.set_empty)
        begin
            for (int a = 0; a < NUM_AXES; a++)
                mean_reg[a] <= '0;
            for (int p = 0; p < NUM_PAIRS; p++)
                cov_reg[p] <= '0;
        end
        else if (cmd.div_store)
        begin
            if (cmd.k < K_BITS'(NUM_AXES))
                mean_reg[cmd.k[1:0]] <= quo_next[MW-1:0];
            else
                cov_reg[j_idx] <= quo_next - prod_ext[QUO_BITS+FRAC_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            empty_reg <= 1'b0;
        else if (cmd.set_empty)
            empty_reg <= 1'b1;
        else if (cmd.div_load)
            empty_reg <= 1'b0;
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
            mean_ext[a] = 64'(mean_reg[a]);
    end

    assign mean_x       = mean_ext[0][MEAN_BITS-1:0];
    assign mean_y       = mean_ext[1][MEAN_BITS-1:0];
    assign mean_z       = mean_ext[2][MEAN_BITS-1:0];
    assign cov_xx       = cov_reg[0][VAR_BITS-1:0];
    assign cov_yy       = cov_reg[1][VAR_BITS-1:0];
    assign cov_zz       = cov_reg[2][VAR_BITS-1:0];
    assign cov_xy       = cov_reg[3];
    assign cov_yz       = cov_reg[4];
    assign cov_xz       = cov_reg[5];
    assign empty_volume = empty_reg;

endmodule

// ===== rtl/volume_moment_covariance.sv =====
// Intensity-weighted centroid and covariance of a voxel volume.
//
// Input channel (in_valid/in_ready, voxel_value): stream voxel intensities in
// raster order, x fastest, then y, then z. One voxel is taken per cycle while
// a volume is being collected; coordinates are counted internally, 1-based.
// Output channel (out_valid/out_ready): one item per volume, issued after the
// last voxel: centroid (Q9.16), six covariance terms (Q16) and empty_volume.
// After the last voxel is accepted, out_valid rises following a settle state
// and nine passes of a shared bit-serial divider (one quotient bit per cycle),
// dividing by the total weight.
// An all-zero volume skips the divider.
// Throughput: one voxel per cycle inside a volume; the divider occupies the
// block between volumes, and in_ready stays low until the result is taken.
// A stalled receiver holds the result steady and blocks new voxels.
// Reset: sizes return to 256 x 256 x 256 and the accumulators clear.
// APB writes to vol_width / vol_height / vol_depth (0x0, 0x4, 0x8) also
// restart the volume; write them only while the block is idle.
module volume_moment_covariance
    import vmc_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int VOXEL_BITS = VOXEL_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_ADDR_BITS-1:0]   paddr,
    input  logic [APB_DATA_BITS-1:0]   pwdata,
    output logic [APB_DATA_BITS-1:0]   prdata,
    output logic                       pready,
    // Voxel stream
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [VOXEL_PORT_BITS-1:0] voxel_value,
    // Result
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [MEAN_BITS-1:0]       mean_x,
    output logic [MEAN_BITS-1:0]       mean_y,
    output logic [MEAN_BITS-1:0]       mean_z,
    output logic [VAR_BITS-1:0]        cov_xx,
    output logic [VAR_BITS-1:0]        cov_yy,
    output logic [VAR_BITS-1:0]        cov_zz,
    output logic signed [COV_BITS-1:0] cov_xy,
    output logic signed [COV_BITS-1:0] cov_yz,
    output logic signed [COV_BITS-1:0] cov_xz,
    output logic                       empty_volume
);

    localparam logic [CFG_BITS-1:0] DIM_RESET = CFG_BITS'(256);

    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic [CFG_BITS-1:0] depth_reg;
    logic                apb_wr;
    logic                cfg_clear;
    reg_idx_t            reg_idx;
    cmd_t                cmd;
    status_t             status;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign apb_wr  = psel && penable && pwrite && pready;

    // Decode the write; an address past the register list writes nothing
    always_comb
    begin
        cfg_clear = 1'b0;
        unique case (reg_idx)
            REG_WIDTH, REG_HEIGHT, REG_DEPTH: cfg_clear = apb_wr;
            default:                          cfg_clear = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            depth_reg  <= DIM_RESET;
        end
        else if (apb_wr)
        begin
            unique case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[CFG_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_BITS-1:0];
                REG_DEPTH:  depth_reg  <= pwdata[CFG_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
            REG_DEPTH:  prdata = APB_DATA_BITS'(depth_reg);
            default:    prdata = '0;
        endcase
    end

    vmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_clear (cfg_clear),
        .status    (status),
        .cmd       (cmd)
    );

    vmc_datapath #(
        .MAX_DIM    (MAX_DIM),
        .VOXEL_BITS (VOXEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_width    (width_reg),
        .cfg_height   (height_reg),
        .cfg_depth    (depth_reg),
        .voxel_value  (voxel_value),
        .mean_x       (mean_x),
        .mean_y       (mean_y),
        .mean_z       (mean_z),
        .cov_xx       (cov_xx),
        .cov_yy       (cov_yy),
        .cov_zz       (cov_zz),
        .cov_xy       (cov_xy),
        .cov_yz       (cov_yz),
        .cov_xz       (cov_xz),
        .empty_volume (empty_volume)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import vmc_pkg::*;

    // Expected centroid and covariance of one volume
    typedef struct {
        logic [MEAN_BITS-1:0] mean_x;
        logic [MEAN_BITS-1:0] mean_y;
        logic [MEAN_BITS-1:0] mean_z;
        logic [VAR_BITS-1:0]  cov_xx;
        logic [VAR_BITS-1:0]  cov_yy;
        logic [VAR_BITS-1:0]  cov_zz;
        logic [COV_BITS-1:0]  cov_xy;
        logic [COV_BITS-1:0]  cov_yz;
        logic [COV_BITS-1:0]  cov_xz;
        logic                 empty;
    } moments_t;

    localparam int DIM_LIMIT   = 256;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_WAIT  = 700;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0]   paddr = '0;
    logic [APB_DATA_BITS-1:0]   pwdata = '0;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [VOXEL_PORT_BITS-1:0] voxel_value = '0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [MEAN_BITS-1:0]       mean_x, mean_y, mean_z;
    logic [VAR_BITS-1:0]        cov_xx, cov_yy, cov_zz;
    logic signed [COV_BITS-1:0] cov_xy, cov_yz, cov_xz;
    logic                       empty_volume;

    volume_moment_covariance i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .voxel_value  (voxel_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean_x       (mean_x),
        .mean_y       (mean_y),
        .mean_z       (mean_z),
        .cov_xx       (cov_xx),
        .cov_yy       (cov_yy),
        .cov_zz       (cov_zz),
        .cov_xy       (cov_xy),
        .cov_yz       (cov_yz),
        .cov_xz       (cov_xz),
        .empty_volume (empty_volume)
    );

    // Voxels waiting for the driver, and volume results waiting for the block
    logic [VOXEL_PORT_BITS-1:0] voxel_fifo[$];
    moments_t                   expected_moments[$];

    int errors = 0;
    int voxels_queued = 0;
    int voxels_taken = 0;
    int volumes_seen = 0;
    int empty_seen = 0;
    int cycle = 0;
    logic hold_request = 1'b0;

    // Shadow of the size registers and the accumulators
    logic [CFG_BITS-1:0] size_reg[3];
    logic [W_BITS-1:0]   weight_sum;
    logic [M1_BITS-1:0]  axis_sum[3];
    logic [M2_BITS-1:0]  pair_sum[6];
    int                  pos[3];

    // Pair order xx yy zz xy yz xz
    int pair_first[6]  = '{0, 1, 2, 0, 1, 0};
    int pair_second[6] = '{0, 1, 2, 1, 2, 2};

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
    end

    // A quiet window with no idling on either side
    function automatic logic take_break();
        if (cycle >= 20000 && cycle < 30000)
            return 1'b0;
        return $urandom_range(99) < 8;
    endfunction

    function automatic int clamp_dim(logic [CFG_BITS-1:0] r);
        if (r == 0)
            return 1;
        if (r > DIM_LIMIT)
            return DIM_LIMIT;
        return int'(r);
    endfunction

    // floor(num * 2^16 / den)
    function automatic logic [63:0] q16_ratio(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        return (q << FRAC_BITS) + ((r << FRAC_BITS) / den);
    endfunction

    task automatic restart_volume();
        weight_sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            axis_sum[k] = '0;
            pos[k] = 0;
        end
        for (int k = 0; k < 6; k++)
            pair_sum[k] = '0;
    endtask

    // Fold one voxel into the moments; on the last voxel queue the result
    task automatic accumulate_voxel(logic [VOXEL_PORT_BITS-1:0] v);
        logic [63:0] c[3];
        logic [63:0] mu[3];
        logic [63:0] cv[6];
        logic        last_voxel;
        int          dims[3];
        moments_t    m;
        for (int k = 0; k < 3; k++)
        begin
            dims[k] = clamp_dim(size_reg[k]);
            c[k] = pos[k] + 1;
        end
        weight_sum = weight_sum + v;
        for (int k = 0; k < 3; k++)
            axis_sum[k] = axis_sum[k] + c[k] * v;
        for (int k = 0; k < 6; k++)
            pair_sum[k] = pair_sum[k] + c[pair_first[k]] * c[pair_second[k]] * v;
        last_voxel = (pos[0] + 1 >= dims[0]) && (pos[1] + 1 >= dims[1])
                     && (pos[2] + 1 >= dims[2]);
        // Advance the raster position, x fastest
        if (pos[0] + 1 >= dims[0])
        begin
            pos[0] = 0;
            if (pos[1] + 1 >= dims[1])
            begin
                pos[1] = 0;
                pos[2] = (pos[2] + 1 >= dims[2]) ? 0 : pos[2] + 1;
            end
            else
                pos[1]++;
        end
        else
            pos[0]++;
        if (!last_voxel)
            return;
        if (weight_sum == 0)
        begin
            m = '{default: '0};
            m.empty = 1'b1;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
                mu[k] = q16_ratio(axis_sum[k], weight_sum);
            for (int k = 0; k < 6; k++)
                cv[k] = q16_ratio(pair_sum[k], weight_sum)
                        - ((mu[pair_first[k]] * mu[pair_second[k]]) >> FRAC_BITS);
            m.mean_x = mu[0][MEAN_BITS-1:0];
            m.mean_y = mu[1][MEAN_BITS-1:0];
            m.mean_z = mu[2][MEAN_BITS-1:0];
            m.cov_xx = cv[0][VAR_BITS-1:0];
            m.cov_yy = cv[1][VAR_BITS-1:0];
            m.cov_zz = cv[2][VAR_BITS-1:0];
            m.cov_xy = cv[3][COV_BITS-1:0];
            m.cov_yz = cv[4][COV_BITS-1:0];
            m.cov_xz = cv[5][COV_BITS-1:0];
            m.empty  = 1'b0;
        end
        expected_moments.push_back(m);
        restart_volume();
    endtask

    // Driver: hold each voxel until taken, pull the next from the fifo
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                accumulate_voxel(voxel_value);
                voxels_taken <= voxels_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (voxel_fifo.size() > 0 && !take_break())
                begin
                    in_valid <= 1'b1;
                    voxel_value <= voxel_fifo.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Long hold-off on request: the block fills and stalls its input
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (hold_request && hold_left == 0)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compare each taken result with the oldest expectation,
    // then decide out_ready for the next cycle
    always @(posedge clk)
    begin
        moments_t m;
        if (rst_n && out_valid && out_ready)
        begin
            volumes_seen++;
            if (expected_moments.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got mean_x %0h",
                         $time, mean_x);
                errors++;
            end
            else
            begin
                m = expected_moments.pop_front();
                if (m.empty)
                    empty_seen++;
                check_field("mean_x", m.mean_x, mean_x);
                check_field("mean_y", m.mean_y, mean_y);
                check_field("mean_z", m.mean_z, mean_z);
                check_field("cov_xx", m.cov_xx, cov_xx);
                check_field("cov_yy", m.cov_yy, cov_yy);
                check_field("cov_zz", m.cov_zz, cov_zz);
                check_field("cov_xy", m.cov_xy, $unsigned(cov_xy));
                check_field("cov_yz", m.cov_yz, $unsigned(cov_yz));
                check_field("cov_xz", m.cov_xz, $unsigned(cov_xz));
                check_field("empty_volume", m.empty, empty_volume);
            end
        end
        if (hold_left > 0)
            out_ready <= 1'b0;
        else
            out_ready <= !take_break();
    end

    // Write one size register, then read it back
    task automatic write_size(reg_idx_t idx, logic [CFG_BITS-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'(4 * int'(idx));
        pwdata  <= APB_DATA_BITS'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        size_reg[int'(idx)] = val;
        restart_volume();
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", APB_DATA_BITS'(val), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_volume(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h,
                              logic [CFG_BITS-1:0] d);
        write_size(REG_WIDTH, w);
        write_size(REG_HEIGHT, h);
        write_size(REG_DEPTH, d);
    endtask

    // Queue whole volumes; style picks the intensity pattern
    task automatic queue_volumes(int count, int style);
        int n;
        n = clamp_dim(size_reg[0]) * clamp_dim(size_reg[1]) * clamp_dim(size_reg[2]);
        repeat (count * n)
        begin
            case (style)
                0:       voxel_fifo.push_back(16'h0000);
                1:       voxel_fifo.push_back(16'hFFFF);
                2:       voxel_fifo.push_back(16'(1 << $urandom_range(15)));
                3:       voxel_fifo.push_back(($urandom_range(3) == 0) ? 16'($urandom) : 16'h0);
                default: voxel_fifo.push_back(16'($urandom));
            endcase
            voxels_queued++;
        end
    endtask

    // Sender pause: wait until every voxel is taken and every result is back
    task automatic drain();
        while (voxels_taken != voxels_queued || expected_moments.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    initial
    begin
        int pick;
        for (int k = 0; k < 3; k++)
            size_reg[k] = 9'd256;
        restart_volume();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single voxels at the intensity extremes
        set_volume(9'd1, 9'd1, 9'd1);
        voxel_fifo.push_back(16'h0000);
        voxel_fifo.push_back(16'hFFFF);
        voxel_fifo.push_back(16'h0001);
        voxels_queued += 3;
        drain();
        // Zero size counts as one
        set_volume(9'd0, 9'd0, 9'd0);
        voxel_fifo.push_back(16'h8000);
        voxels_queued++;
        drain();
        // Empty volume, then a skewed ramp
        set_volume(9'd2, 9'd2, 9'd2);
        queue_volumes(1, 0);
        drain();
        set_volume(9'd2, 9'd3, 9'd2);
        for (int k = 0; k < 12; k++)
        begin
            voxel_fifo.push_back(16'(k * 5000 + 7));
            voxels_queued++;
        end
        drain();

        // Size extremes: oversize clamps to the limit, full-scale sums
        set_volume(9'd511, 9'd1, 9'd1);
        queue_volumes(1, 1);
        drain();
        set_volume(9'd1, 9'd1, 9'd256);
        queue_volumes(1, 4);
        drain();

        // Hold the receiver off while several volumes are offered
        set_volume(9'd2, 9'd2, 9'd1);
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        queue_volumes(4, 4);
        drain();

        // Random sizes, mostly small, an occasional extreme axis
        while (voxels_queued < 1650)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
            begin
                case ($urandom_range(2))
                    0:       set_volume(9'($urandom_range(256, 511)), 9'd1, 9'd1);
                    1:       set_volume(9'd1, 9'($urandom_range(200, 511)), 9'd1);
                    default: set_volume(9'd0, 9'd1, 9'($urandom_range(256, 300)));
                endcase
                queue_volumes(1, $urandom_range(4));
            end
            else
            begin
                set_volume(9'($urandom_range(4)), 9'($urandom_range(4)),
                           9'($urandom_range(4)));
                queue_volumes($urandom_range(1, 4), $urandom_range(6));
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Checked %0d volumes (%0d empty) from %0d voxels.",
                 volumes_seen, empty_seen, voxels_taken);
        $display("Sizes covered zero, one, small and clamped full-scale axes.");
        if (errors == 0 && expected_moments.size() == 0)
            $display("** volume_moment_covariance: PASSED **");
        else
            $display("** volume_moment_covariance: FAILED **");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout with %0d results outstanding.", expected_moments.size());
        $display("** volume_moment_covariance: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vmc_pkg.sv
rtl/vmc_ctrl.sv
rtl/vmc_datapath.sv
rtl/volume_moment_covariance.sv
bench/tb.sv
